// ----- rtl/rhcb_pkg.sv -----
// Package for the rolling hash chunk boundary block.
// Holds sizes, item kinds, result codes and the structs shared by the modules.
// No dependencies.
package rhcb_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int TABLE_ENTRIES = 256;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int MAX_WINDOW    = 48;
  localparam int WIN_W         = 6;
  localparam int OUTQ_DEPTH    = 4;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd48;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VALUE   = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PRIME   = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_HIT   = 2'd1,
    STATUS_LIMIT = 2'd2
  } status_t;

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [63:0] hash;
  } result_t;

endpackage

// ----- rtl/rhcb_ram.sv -----
// Generic synchronous RAM: one write port, one read port, registered read.
// Read of the address being written returns the old contents. No dependencies.
module rhcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rhcb_fetch.sv -----
// Front of the pipeline: history ring, write pointer and the byte table banks.
// Reads the leaving byte and the entering table word, then the leaving table word. Uses rhcb_pkg and rhcb_ram.
module rhcb_fetch #(
  parameter int HISTORY_DEPTH = rhcb_pkg::HISTORY_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  rhcb_pkg::kind_t           in_kind,
  input  logic [7:0]                in_byte,
  input  logic [63:0]               in_word,
  input  logic                      in_last,
  input  logic [rhcb_pkg::WIN_W-1:0] win,
  output rhcb_pkg::ctrl_t           s2_ctrl,
  output logic [63:0]               enter_word,
  output logic [63:0]               leave_word
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW    = ((PTR_W > rhcb_pkg::WIN_W) ? PTR_W : rhcb_pkg::WIN_W) + 1;

  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         wr_ptr_next;
  logic [PTR_W:0]           ptr_inc;
  logic [PTR_W-1:0]         rd_idx;
  logic [CW-1:0]            p_ext;
  logic [CW-1:0]            w_ext;
  logic [CW-1:0]            q_ext;
  logic [HISTORY_DEPTH-1:0] ring_valid;
  logic                     push;
  logic                     load;
  logic [7:0]               ring_rdata;
  logic [7:0]               old_byte;
  logic                     s1_old_valid;
  rhcb_pkg::ctrl_t          s1_ctrl;
  logic [63:0]              enter_s1;

  assign push = in_fire && (in_kind == rhcb_pkg::KIND_PRIME || in_kind == rhcb_pkg::KIND_DATA);
  assign load = in_fire && (in_kind == rhcb_pkg::KIND_LOAD);

  // leaving byte sits w places behind the write pointer, modulo the ring depth
  always_comb begin
    p_ext = CW'(wr_ptr);
    w_ext = CW'(win);
    if (p_ext >= w_ext) begin
      q_ext = p_ext - w_ext;
    end else begin
      q_ext = p_ext + CW'(HISTORY_DEPTH) - w_ext;
    end
    rd_idx  = q_ext[PTR_W-1:0];
    ptr_inc = {1'b0, wr_ptr} + (PTR_W + 1)'(1);
    if (ptr_inc == (PTR_W + 1)'(HISTORY_DEPTH)) begin
      wr_ptr_next = '0;
    end else begin
      wr_ptr_next = ptr_inc[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      ring_valid <= '0;
    end else if (push) begin
      wr_ptr             <= wr_ptr_next;
      ring_valid[wr_ptr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl.valid <= 1'b0;
      s2_ctrl.valid <= 1'b0;
    end else begin
      s1_ctrl.valid <= in_fire;
      s2_ctrl.valid <= s1_ctrl.valid;
    end
    s1_ctrl.kind  <= in_kind;
    s1_ctrl.last  <= in_last;
    s1_old_valid  <= ring_valid[rd_idx];
    s2_ctrl.kind  <= s1_ctrl.kind;
    s2_ctrl.last  <= s1_ctrl.last;
    enter_word    <= enter_s1;
  end

  // never-written ring slots read as zero
  assign old_byte = s1_old_valid ? ring_rdata : 8'h00;

  rhcb_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (in_byte),
    .raddr (rd_idx),
    .rdata (ring_rdata)
  );

  // table bank for the entering byte
  rhcb_ram #(
    .WIDTH (64),
    .DEPTH (rhcb_pkg::TABLE_ENTRIES)
  ) u_table_enter (
    .clk   (clk),
    .we    (load),
    .waddr (in_byte),
    .wdata (in_word),
    .raddr (in_byte),
    .rdata (enter_s1)
  );

  // mirror bank for the leaving byte, addressed in the cycle after the entering bank
  rhcb_ram #(
    .WIDTH (64),
    .DEPTH (rhcb_pkg::TABLE_ENTRIES)
  ) u_table_leave (
    .clk   (clk),
    .we    (load),
    .waddr (in_byte),
    .wdata (in_word),
    .raddr (old_byte),
    .rdata (leave_word)
  );

endmodule

// ----- rtl/rhcb_update.sv -----
// Hash and count update stage: rolls the hash and checks for a boundary.
// Uses rhcb_pkg; fed by rhcb_fetch, feeds rhcb_outq.
module rhcb_update (
  input  logic                       clk,
  input  logic                       rst,
  input  rhcb_pkg::ctrl_t            s2_ctrl,
  input  logic [63:0]                enter_word,
  input  logic [63:0]                leave_word,
  input  logic [rhcb_pkg::WIN_W-1:0] win,
  input  logic [31:0]                match_mask,
  input  logic [31:0]                match_value,
  output logic                       res_valid,
  output rhcb_pkg::result_t          res
);

  logic [63:0]       hash;
  logic [63:0]       hash_next;
  logic [31:0]       count;
  logic [31:0]       count_next;
  logic [31:0]       count_inc;
  logic [63:0]       rot1;
  logic [63:0]       leave_rot;
  logic [6:0]        rsh;
  logic [31:0]       offset;
  rhcb_pkg::status_t status;

  always_comb begin
    rot1      = {hash[62:0], hash[63]};
    rsh       = 7'd64 - {1'b0, win};
    leave_rot = (leave_word << win) | (leave_word >> rsh);
    count_inc = (count == '1) ? count : count + 32'd1;
    hash_next  = hash;
    count_next = count;
    offset     = count;
    status     = rhcb_pkg::STATUS_NONE;
    if (s2_ctrl.valid) begin
      unique case (s2_ctrl.kind)
        rhcb_pkg::KIND_LOAD: begin
          hash_next = hash;
        end
        rhcb_pkg::KIND_PRIME: begin
          hash_next = rot1 ^ enter_word;
        end
        rhcb_pkg::KIND_DATA: begin
          hash_next = rot1 ^ enter_word ^ leave_rot;
          offset    = count_inc;
          if ((hash_next[31:0] & match_mask) == match_value) begin
            status = rhcb_pkg::STATUS_HIT;
          end else if (s2_ctrl.last) begin
            status = rhcb_pkg::STATUS_LIMIT;
          end
          count_next = (status != rhcb_pkg::STATUS_NONE) ? 32'd0 : count_inc;
        end
        rhcb_pkg::KIND_RESTART: begin
          hash_next  = '0;
          count_next = '0;
          offset     = '0;
        end
        default: begin
          hash_next = hash;
        end
      endcase
    end
    res_valid  = s2_ctrl.valid;
    res.status = status;
    res.offset = offset;
    res.hash   = hash_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= '0;
      count <= '0;
    end else begin
      hash  <= hash_next;
      count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_status_data_only: assert property (@(posedge clk) disable iff (rst)
    (res_valid && s2_ctrl.kind != rhcb_pkg::KIND_DATA) |-> res.status == rhcb_pkg::STATUS_NONE)
    else $error("boundary status on a non-data beat");
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != rhcb_pkg::STATUS_NONE) |=> count == 32'd0)
    else $error("count not restarted after a boundary");
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (s2_ctrl.valid && s2_ctrl.kind == rhcb_pkg::KIND_RESTART) |=> hash == 64'd0)
    else $error("hash not cleared by restart");
`endif

endmodule

// ----- rtl/rhcb_outq.sv -----
// Output queue with credit count: holds results until the sink takes them.
// Grants input beats only while a queue slot is still free to reserve. Uses rhcb_pkg.
module rhcb_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  output logic              in_ready,
  input  logic              push,
  input  rhcb_pkg::result_t wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rhcb_pkg::result_t out_data
);

  localparam int QA_W = $clog2(rhcb_pkg::OUTQ_DEPTH);
  localparam int QC_W = QA_W + 1;

  rhcb_pkg::result_t slots [rhcb_pkg::OUTQ_DEPTH];
  logic [QA_W-1:0]   wr_ptr;
  logic [QA_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   fill;
  logic [QC_W-1:0]   outstanding;
  logic              pop;

  assign out_valid = (fill != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];
  // one credit per beat between acceptance and delivery
  assign in_ready  = (outstanding < QC_W'(rhcb_pkg::OUTQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fill        <= '0;
      outstanding <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QC_W'(1);
      end else if (!push && pop) begin
        fill <= fill - QC_W'(1);
      end
      if (in_fire && !pop) begin
        outstanding <= outstanding + QC_W'(1);
      end else if (!in_fire && pop) begin
        outstanding <= outstanding - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  a_fill_within_credit: assert property (@(posedge clk) disable iff (rst)
    fill <= outstanding)
    else $error("queue holds more results than beats in flight");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> fill < QC_W'(rhcb_pkg::OUTQ_DEPTH))
    else $error("result pushed into a full queue");
`endif

endmodule

// ----- rtl/rolling_hash_chunk_boundary.sv -----
// Top level of the buzhash rolling hash chunk boundary finder.
// Holds the configuration registers; uses rhcb_pkg, rhcb_fetch, rhcb_update, rhcb_outq.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready  | tuser kind, tdata byte+word, tlast
//  m_axis   | out       | m_axis_tvalid/tready  | tuser status, tdata offset+hash
//  cfg      | in        | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One beat per cycle in each direction while neither side stalls; each result is
// registered behind the two dependent memory reads (history ring, then table).
// The output queue holds four results; s_axis_tready drops once four beats are
// accepted and not yet delivered. Reset is synchronous; ring slots read as zero
// at once, the byte table is undefined until loaded, and there is no clearing pass.
module rolling_hash_chunk_boundary #(
  parameter int HISTORY_DEPTH = rhcb_pkg::HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [7:0] data_byte, [71:8] table_word
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  logic        s_axis_tlast,   // last_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] offset, [95:32] hash_value
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [rhcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int WIN_TOP = (HISTORY_DEPTH < rhcb_pkg::MAX_WINDOW) ?
                           HISTORY_DEPTH : rhcb_pkg::MAX_WINDOW;

  logic [rhcb_pkg::WIN_W-1:0] window_length;
  logic [31:0]                match_mask;
  logic [31:0]                match_value;
  logic [rhcb_pkg::WIN_W-1:0] win;
  logic                       in_fire;
  rhcb_pkg::ctrl_t            s2_ctrl;
  logic [63:0]                enter_word;
  logic [63:0]                leave_word;
  logic                       res_valid;
  rhcb_pkg::result_t          res;
  rhcb_pkg::result_t          out_data;

  // configuration writes land directly; undefined indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rhcb_pkg::WINDOW_RESET;
      match_mask    <= '0;
      match_value   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rhcb_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_wdata[rhcb_pkg::WIN_W-1:0];
        rhcb_pkg::CFG_MATCH_MASK:    match_mask    <= cfg_wdata;
        rhcb_pkg::CFG_MATCH_VALUE:   match_value   <= cfg_wdata;
        default:                     match_value   <= match_value;
      endcase
    end
  end

  // clamp the window to 1 .. min(MAX_WINDOW, ring depth)
  always_comb begin
    if (window_length == '0) begin
      win = rhcb_pkg::WIN_W'(1);
    end else if ({1'b0, window_length} > (rhcb_pkg::WIN_W + 1)'(WIN_TOP)) begin
      win = rhcb_pkg::WIN_W'(WIN_TOP);
    end else begin
      win = window_length;
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  rhcb_fetch #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_kind    (rhcb_pkg::kind_t'(s_axis_tuser)),
    .in_byte    (s_axis_tdata[7:0]),
    .in_word    (s_axis_tdata[71:8]),
    .in_last    (s_axis_tlast),
    .win        (win),
    .s2_ctrl    (s2_ctrl),
    .enter_word (enter_word),
    .leave_word (leave_word)
  );

  rhcb_update u_update (
    .clk         (clk),
    .rst         (rst),
    .s2_ctrl     (s2_ctrl),
    .enter_word  (enter_word),
    .leave_word  (leave_word),
    .win         (win),
    .match_mask  (match_mask),
    .match_value (match_value),
    .res_valid   (res_valid),
    .res         (res)
  );

  rhcb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_ready  (s_axis_tready),
    .push      (res_valid),
    .wr_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {out_data.hash, out_data.offset};
  assign m_axis_tuser = out_data.status;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for rolling_hash_chunk_boundary.
// Drives typed hash items on the input stream, predicts each result beat with its own
// buzhash model and compares it field by field; depends only on rhcb_pkg and the RTL.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int SETTLE_CYCLES  = 8;     // beyond the pipeline latency
  localparam int LONG_HOLD      = 80;    // receiver hold-off, well past the queue depth
  localparam logic [rhcb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One input beat as the generator and the predictor see it.
  typedef struct packed {
    rhcb_pkg::kind_t kind;
    logic [7:0]      data_byte;
    logic [63:0]     table_word;
    logic            last;
  } hash_item_t;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [71:0]                    s_axis_tdata  = '0;   // [7:0] data_byte, [71:8] table_word
  logic [1:0]                     s_axis_tuser  = '0;   // [1:0] kind
  logic                           s_axis_tlast  = 1'b0; // last_of_buffer
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [95:0]                    m_axis_tdata;         // [31:0] offset, [95:32] hash_value
  logic [1:0]                     m_axis_tuser;         // [1:0] status
  logic                           cfg_we        = 1'b0;
  logic [rhcb_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [31:0]                    cfg_wdata     = '0;

  rolling_hash_chunk_boundary dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Hash predictor: private copy of the table, the byte history and the counters.
  // ---------------------------------------------------------------------------
  logic [63:0] table_copy [rhcb_pkg::TABLE_ENTRIES];
  logic [7:0]  history_copy [rhcb_pkg::HISTORY_DEPTH];
  int unsigned history_head    = 0;
  logic [63:0] hash_acc        = '0;
  logic [31:0] bytes_since_cut = '0;
  logic [5:0]  window_cfg      = rhcb_pkg::WINDOW_RESET;
  logic [31:0] mask_cfg        = '0;
  logic [31:0] trigger_cfg     = '0;

  rhcb_pkg::result_t predicted_boundaries [$];  // result beats still owed by the block
  hash_item_t        stream_items [$];          // beats waiting for the driver

  int mismatch_count = 0;
  int beats_in       = 0;
  int results_seen   = 0;
  int hit_count      = 0;
  int limit_count    = 0;
  int config_count   = 0;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
    r = r % 64;
    return (r == 0) ? v : ((v << r) | (v >> (64 - r)));
  endfunction

  // Clamp the window register into 1..min(MAX_WINDOW, HISTORY_DEPTH).
  function automatic int unsigned span_of(input logic [5:0] w);
    int unsigned top;
    top = (rhcb_pkg::HISTORY_DEPTH < rhcb_pkg::MAX_WINDOW) ?
          rhcb_pkg::HISTORY_DEPTH : rhcb_pkg::MAX_WINDOW;
    if (w < 1) return 1;
    if (w > top) return top;
    return w;
  endfunction

  // Apply one accepted beat to the model and queue the result it owes.
  function automatic void advance_hash_model(input hash_item_t it);
    rhcb_pkg::result_t r;
    int unsigned       w;
    logic [7:0]        leaving;
    r.status = rhcb_pkg::STATUS_NONE;
    case (it.kind)
      rhcb_pkg::KIND_LOAD: table_copy[it.data_byte] = it.table_word;
      rhcb_pkg::KIND_PRIME: begin
        hash_acc = rotl(hash_acc, 1) ^ table_copy[it.data_byte];
        history_copy[history_head] = it.data_byte;
        history_head = (history_head + 1) % rhcb_pkg::HISTORY_DEPTH;
      end
      rhcb_pkg::KIND_DATA: begin
        // the leaving byte sits w slots behind the write head
        w = span_of(window_cfg);
        leaving = history_copy[(history_head + rhcb_pkg::HISTORY_DEPTH - w)
                               % rhcb_pkg::HISTORY_DEPTH];
        hash_acc = rotl(hash_acc, 1) ^ table_copy[it.data_byte] ^ rotl(table_copy[leaving], w);
        history_copy[history_head] = it.data_byte;
        history_head = (history_head + 1) % rhcb_pkg::HISTORY_DEPTH;
        if (bytes_since_cut != '1) bytes_since_cut++;
        // hit wins over the buffer limit
        if ((hash_acc[31:0] & mask_cfg) == trigger_cfg) r.status = rhcb_pkg::STATUS_HIT;
        else if (it.last) r.status = rhcb_pkg::STATUS_LIMIT;
      end
      default: begin
        hash_acc = '0;
        bytes_since_cut = '0;
      end
    endcase
    r.offset = bytes_since_cut;
    r.hash   = hash_acc;
    if (r.status != rhcb_pkg::STATUS_NONE) bytes_since_cut = '0;
    predicted_boundaries.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; predict on acceptance.
  // ---------------------------------------------------------------------------
  hash_item_t offered_item;
  int         burst_left = 1;
  int         gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_hash_model(offered_item);
        beats_in++;
      end
      // advance only when the held beat is gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (stream_items.size() > 0) begin
          offered_item = stream_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered_item.table_word, offered_item.data_byte};
          s_axis_tuser  <= offered_item.kind;
          s_axis_tlast  <= offered_item.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(10, 20);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: own stall pattern, one long hold-off, field-by-field compare.
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle       = 0;
  int          hold_left      = 0;
  bit          long_hold_done = 1'b0;

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch on %s at result %0d: expected %h, got %h",
             field, results_seen, want, got);
    mismatch_count++;
  endtask

  task automatic check_boundary_report();
    rhcb_pkg::result_t want;
    if (predicted_boundaries.size() == 0) begin
      report_mismatch("unexpected result beat", '0, m_axis_tdata[95:32]);
      return;
    end
    want = predicted_boundaries.pop_front();
    if (m_axis_tuser !== want.status)
      report_mismatch("status", want.status, m_axis_tuser);
    if (m_axis_tdata[31:0] !== want.offset)
      report_mismatch("offset", want.offset, m_axis_tdata[31:0]);
    if (m_axis_tdata[95:32] !== want.hash)
      report_mismatch("hash_value", want.hash, m_axis_tdata[95:32]);
    if (m_axis_tuser == rhcb_pkg::STATUS_HIT) hit_count++;
    if (m_axis_tuser == rhcb_pkg::STATUS_LIMIT) limit_count++;
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_boundary_report();
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150 && s_axis_tvalid) begin
      // hold off while the sender keeps offering, so the block fills and stalls
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_cycle % 8 != 0);
      endcase
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. Prime and data bytes come only from loaded table
  // entries; entry 0 is loaded first because the history starts out as zeros.
  // ---------------------------------------------------------------------------
  logic [7:0]  loaded_list [$];
  bit          loaded_flag [rhcb_pkg::TABLE_ENTRIES];
  int unsigned gen_span = rhcb_pkg::MAX_WINDOW;

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_loaded_byte();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic queue_item(input rhcb_pkg::kind_t kind, input logic [7:0] b,
                            input logic [63:0] word, input logic last);
    hash_item_t it;
    it.kind       = kind;
    it.data_byte  = b;
    it.table_word = word;
    it.last       = last;
    if (kind == rhcb_pkg::KIND_LOAD && !loaded_flag[b]) begin
      loaded_flag[b] = 1'b1;
      loaded_list.push_back(b);
    end
    stream_items.push_back(it);
  endtask

  // One well-formed buffer: usually a restart, a full (or short) prime, then a data run.
  // Trim the prime and the run to the room left in the phase.
  task automatic queue_buffer(input int unsigned room);
    int unsigned primes;
    int unsigned run;
    if ($urandom_range(0, 4) != 0)
      queue_item(rhcb_pkg::KIND_RESTART, $urandom, random_word(), $urandom_range(0, 1));
    primes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gen_span) : gen_span;
    if (room < 2) room = 2;
    if (primes > room - 1) primes = room - 1;
    run = $urandom_range(1, 24);
    if (run > room - primes) run = room - primes;
    for (int i = 0; i < primes; i++)
      queue_item(rhcb_pkg::KIND_PRIME, pick_loaded_byte(), random_word(),
                 $urandom_range(0, 1));
    for (int i = 0; i < run; i++)
      queue_item(rhcb_pkg::KIND_DATA, pick_loaded_byte(), random_word(),
                 (i == run - 1) && ($urandom_range(0, 3) != 0));
  endtask

  task automatic queue_random_traffic(input int n);
    int              stop;
    rhcb_pkg::kind_t k;
    stop = stream_items.size() + n;
    while (stream_items.size() < stop) begin
      case ($urandom_range(0, 9))
        0: queue_item(rhcb_pkg::KIND_LOAD, $urandom, random_word(), $urandom_range(0, 1));
        1: begin
          // noise: a lone beat of any kind
          k = rhcb_pkg::kind_t'($urandom_range(0, 3));
          if (k == rhcb_pkg::KIND_LOAD || k == rhcb_pkg::KIND_RESTART)
            queue_item(k, $urandom, random_word(), $urandom_range(0, 1));
          else
            queue_item(k, pick_loaded_byte(), random_word(), $urandom_range(0, 1));
        end
        default: queue_buffer(stop - stream_items.size());
      endcase
    end
  endtask

  // Wait until every queued beat went in and every result came out, then settle.
  // Sample on the falling edge so the driver's updates of this cycle are visible.
  task automatic wait_until_drained();
    while (stream_items.size() > 0 || s_axis_tvalid || predicted_boundaries.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold cfg_we high across consecutive writes; the caller lowers it once.
  task automatic write_register(input logic [rhcb_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] value);
    case (idx)
      rhcb_pkg::CFG_WINDOW_LENGTH: window_cfg  = value[rhcb_pkg::WIN_W-1:0];
      rhcb_pkg::CFG_MATCH_MASK:    mask_cfg    = value;
      rhcb_pkg::CFG_MATCH_VALUE:   trigger_cfg = value;
      default: ;  // undefined index: no effect
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] win, input logic [31:0] mask,
                            input logic [31:0] trigger);
    write_register(rhcb_pkg::CFG_WINDOW_LENGTH, win);
    write_register(rhcb_pkg::CFG_MATCH_MASK, mask);
    write_register(rhcb_pkg::CFG_MATCH_VALUE, trigger);
    cfg_we <= 1'b0;
    gen_span = span_of(win[rhcb_pkg::WIN_W-1:0]);
    config_count++;
  endtask

  task automatic run_phase(input logic [31:0] win, input logic [31:0] mask,
                           input logic [31:0] trigger, input int n);
    wait_until_drained();
    set_config(win, mask, trigger);
    queue_random_traffic(n);
  endtask

  initial begin
    logic [31:0] sparse_mask;
    for (int i = 0; i < rhcb_pkg::HISTORY_DEPTH; i++) history_copy[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset configuration (window 48, mask 0, value 0): every data byte hits.
    queue_item(rhcb_pkg::KIND_LOAD, 8'h00, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_LOAD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_item(rhcb_pkg::KIND_LOAD, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_item(rhcb_pkg::KIND_LOAD, 8'h55, 64'h0123_4567_89AB_CDEF, 1'b0);
    queue_item(rhcb_pkg::KIND_PRIME, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);  // tlast ignored
    queue_item(rhcb_pkg::KIND_PRIME, 8'hAA, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_DATA, 8'h55, 64'h0, 1'b0);  // short prime: leaving byte is zero
    queue_item(rhcb_pkg::KIND_DATA, 8'h00, 64'h0, 1'b1);  // hit and limit at once
    queue_item(rhcb_pkg::KIND_RESTART, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_item(rhcb_pkg::KIND_DATA, 8'hFF, 64'h5555_5555_5555_5555, 1'b0);
    queue_item(rhcb_pkg::KIND_LOAD, 8'h00, random_word(), 1'b0);  // reload mid-stream
    queue_item(rhcb_pkg::KIND_DATA, 8'hAA, 64'h0, 1'b1);
    wait_until_drained();

    // Directed, window register 0 (clamps to 1), full mask: limits instead of hits.
    write_register(CFG_UNUSED, $urandom);
    set_config(32'd0, 32'hFFFF_FFFF, 32'h1234_5678);
    queue_item(rhcb_pkg::KIND_RESTART, 8'h00, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_PRIME, 8'h55, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_DATA, 8'hAA, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_DATA, 8'hFF, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_DATA, 8'h00, 64'h0, 1'b1);
    queue_item(rhcb_pkg::KIND_DATA, 8'h55, 64'h0, 1'b0);
    queue_item(rhcb_pkg::KIND_RESTART, 8'hAA, 64'h0, 1'b0);

    // Random phases across window lengths and match settings.
    run_phase(32'd1,  32'h0000_0003, 32'h0000_0001, 60);
    run_phase(32'd63, 32'h0000_000F, 32'h0000_0000, 70);  // clamps to 48
    run_phase(32'd48, 32'hFFFF_FFFF, $urandom, 55);        // hits practically never
    run_phase(32'd17, 32'h0000_0000, 32'h0000_0001, 45);  // hits impossible
    sparse_mask = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31))
                | (32'd1 << $urandom_range(0, 31));
    run_phase($urandom_range(0, 63), sparse_mask, $urandom & sparse_mask, 60);
    run_phase(32'd32, 32'h8000_0001, 32'h8000_0000, 50);
    run_phase(32'd8,  32'h0000_0007, 32'h0000_0005, 60);
    run_phase(32'd0,  32'h0000_0000, 32'h0000_0000, 50);  // every data byte hits
    wait_until_drained();

    $display("covered %0d input beats and %0d result beats over %0d register settings",
             beats_in, results_seen, config_count);
    $display("boundaries seen: %0d hash hits, %0d buffer limits; %0d table entries loaded",
             hit_count, limit_count, loaded_list.size());
    if (mismatch_count == 0 && predicted_boundaries.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rhcb_pkg.sv
rtl/rhcb_ram.sv
rtl/rhcb_fetch.sv
rtl/rhcb_update.sv
rtl/rhcb_outq.sv
rtl/rolling_hash_chunk_boundary.sv
tb/testbench.sv
